// ----- rtl/core/tdvt_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the td value table block
package tdvt_pkg;

	localparam int VAL_W      = 32;
	localparam int REG_W      = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int GENES_DEF  = 10;
	localparam int IDX_MAX_W  = 20;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	// arithmetic widths of the update datapath
	localparam int MULD_W = REG_W + 1 + VAL_W;      // discount * post
	localparam int DP_W   = MULD_W - 16;            // floored discounted post
	localparam int D_W    = DP_W + 1;               // reward + dp - pre
	localparam int MULL_W = REG_W + 1 + D_W;        // learning_rate * d
	localparam int INC_W  = MULL_W - 16;            // floored increment
	localparam int SUM_W  = INC_W + 1;              // pre + inc

	localparam logic [CFG_IDX_W-1:0] CFG_LR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISC = 1'b1;

	localparam logic [REG_W-1:0] LR_RESET   = 17'd6554;
	localparam logic [REG_W-1:0] DISC_RESET = 17'd58982;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef enum logic {
		OP_READ,
		OP_UPDATE
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [IDX_MAX_W-1:0]  si;
		logic [IDX_MAX_W-1:0]  ni;
		logic [VAL_W-1:0]      reward;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/tdvt_front.sv -----
`timescale 1ns / 1ps
// command intake: accepts a command, classifies it and hands it to the queue
module tdvt_front
	import tdvt_pkg::*;
#(
	parameter int GENES = GENES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    cmd,
	input  logic [GENES-1:0]        state_index,
	input  logic [GENES-1:0]        next_index,
	input  logic signed [VAL_W-1:0] reward,
	input  logic                    clearing,
	input  q_stat_t                 q_stat,
	output logic                    busy,
	output logic                    push,
	output item_t                   push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;
	logic  accept;

	// only an update with a strictly positive reward touches the table
	always_comb begin
		item_in.op     = (cmd == CMD_UPDATE && reward > 0) ? OP_UPDATE : OP_READ;
		item_in.si     = IDX_MAX_W'(state_index);
		item_in.ni     = IDX_MAX_W'(next_index);
		item_in.reward = reward;
	end

	assign push   = valid_s1 & ~q_stat.full;
	assign busy   = clearing | (valid_s1 & q_stat.full);
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	assign push_item = item_s1;

endmodule

// ----- rtl/core/tdvt_queue.sv -----
`timescale 1ns / 1ps
// short command queue between intake and execution
module tdvt_queue
	import tdvt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	item_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue read while empty");

endmodule

// ----- rtl/core/tdvt_back.sv -----
`timescale 1ns / 1ps
// execution: value table memory, clearing pass and the td update datapath
module tdvt_back
	import tdvt_pkg::*;
#(
	parameter int GENES = GENES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [REG_W-1:0]        step_size,
	input  logic [REG_W-1:0]        discount,
	input  item_t                   head,
	input  q_stat_t                 q_stat,
	output logic                    pop,
	output logic                    clearing,
	output logic                    done,
	output logic [VAL_W-1:0]        value,
	output logic                    written
);

	localparam int DEPTH = 1 << GENES;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PRE   = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;
	localparam logic [2:0] ST_DIFF  = 3'd4;
	localparam logic [2:0] ST_MULLR = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;

	logic [2:0]               state_q;
	logic [GENES-1:0]         clr_q;

	logic [VAL_W-1:0]         mem [DEPTH];
	logic signed [VAL_W-1:0]  rd_data_q;
	logic [GENES-1:0]         rd_addr;
	logic                     mem_we;
	logic [GENES-1:0]         wr_addr;
	logic [VAL_W-1:0]         wr_data;

	op_t                      op_q;
	logic [GENES-1:0]         si_q;
	logic [GENES-1:0]         ni_q;
	logic [VAL_W-1:0]         reward_q;
	logic [VAL_W-1:0]         pre_q;

	logic signed [MULD_W-1:0] mul_d;
	logic signed [MULD_W-1:0] mul_d_q;
	logic [DP_W-1:0]          dp;
	logic [D_W-1:0]           d_next;
	logic signed [D_W-1:0]    d_q;
	logic signed [MULL_W-1:0] mul_l;
	logic signed [MULL_W-1:0] mul_l_q;
	logic [INC_W-1:0]         inc;
	logic [SUM_W-1:0]         sum;
	logic [VAL_W-1:0]         sat_val;

	logic                     done_q;
	logic [VAL_W-1:0]         value_q;
	logic                     written_q;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	// the queue head is read as it is popped, the next-state entry in the following cycle
	assign rd_addr = (state_q == ST_IDLE) ? head.si[GENES-1:0] : ni_q;

	// datapath; shifting the product right floors toward minus infinity
	assign mul_d  = $signed({1'b0, discount}) * rd_data_q;
	assign dp     = mul_d_q[MULD_W-1:16];
	assign d_next = {{(D_W-VAL_W){reward_q[VAL_W-1]}}, reward_q}
	              + {dp[DP_W-1], dp}
	              - {{(D_W-VAL_W){pre_q[VAL_W-1]}}, pre_q};
	assign mul_l  = $signed({1'b0, step_size}) * d_q;
	assign inc    = mul_l_q[MULL_W-1:16];
	assign sum    = {inc[INC_W-1], inc} + {{(SUM_W-VAL_W){pre_q[VAL_W-1]}}, pre_q};

	always_comb begin
		if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
			sat_val = sum[VAL_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = si_q;
		wr_data = sat_val;
		if (state_q == ST_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_WRITE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			written_q <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			written_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					if (op_q == OP_UPDATE) begin
						state_q <= ST_POST;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_POST:  state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_MULLR;
				ST_MULLR: state_q <= ST_WRITE;
				ST_WRITE: begin
					done_q    <= 1'b1;
					written_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q     <= head.op;
			si_q     <= head.si[GENES-1:0];
			ni_q     <= head.ni[GENES-1:0];
			reward_q <= head.reward;
		end
		if (state_q == ST_PRE) begin
			pre_q   <= rd_data_q;
			value_q <= rd_data_q;
		end
		if (state_q == ST_POST) begin
			mul_d_q <= mul_d;
		end
		if (state_q == ST_DIFF) begin
			d_q <= $signed(d_next);
		end
		if (state_q == ST_MULLR) begin
			mul_l_q <= mul_l;
		end
		if (state_q == ST_WRITE) begin
			value_q <= sat_val;
		end
	end

	assign done    = done_q;
	assign value   = value_q;
	assign written = written_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_PRE || $past(state_q) == ST_WRITE))
		else $error("result strobe without a finished command");

	a_written_done: assert property (@(posedge clk) disable iff (!arst_n)
		written_q |-> done_q)
		else $error("written flag outside a result");

	a_written_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && written_q) |-> ($past(mem_we) && $past(wr_addr) == si_q))
		else $error("update reported without a table write");

endmodule

// ----- rtl/core/td_value_table_update.sv -----
`timescale 1ns / 1ps
// top level of the td(0) value table: config registers, intake, queue, execution
//
// usage
//  - command channel: a command transfer happens at a rising edge with start high and
//    busy low; cmd, state_index, next_index and reward are sampled at that edge
//  - result channel: done is high for exactly one cycle with value and written; the
//    receiver cannot hold results off, so every strobe is a transfer
//  - config port: cfg_we writes cfg_data (low 17 bits) into step_size (index 0)
//    or discount (index 1); write only while no command is in flight
//  - to done: intake register, queue, then a table read for a lookup or an update with
//    a non-positive reward; a writing update adds the discount multiply, difference,
//    step-size multiply and table write; execution runs one command at a time,
//    paced by the single table read port and the two chained multiplies
//  - a two-entry queue lets new commands come in while execution is busy; busy rises
//    once the queue and the intake register are both occupied
//  - reset: after arst_n releases, a clearing pass zeroes the table, one entry per
//    cycle, all 2**GENES entries; busy is high throughout
//  - results come out in command order
module td_value_table_update
	import tdvt_pkg::*;
#(
	parameter int GENES = GENES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cmd,
	input  logic [GENES-1:0]        state_index,
	input  logic [GENES-1:0]        next_index,
	input  logic signed [VAL_W-1:0] reward,
	output logic                    done,
	output logic signed [VAL_W-1:0] value,
	output logic                    written,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	logic [REG_W-1:0] lr_q;
	logic [REG_W-1:0] disc_q;

	logic     clearing;
	logic     push;
	logic     pop;
	item_t    push_item;
	item_t    head;
	q_stat_t  q_stat;
	logic [VAL_W-1:0] value_raw;

	// config registers, used as written (above 1.0 allowed)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LR_RESET;
			disc_q <= DISC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LR:   lr_q   <= cfg_data;
				CFG_DISC: disc_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// intake and classification
	tdvt_front #(
		.GENES(GENES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.state_index (state_index),
		.next_index  (next_index),
		.reward      (reward),
		.clearing    (clearing),
		.q_stat      (q_stat),
		.busy        (busy),
		.push        (push),
		.push_item   (push_item)
	);

	// decouples intake from execution
	tdvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// table memory and update datapath
	tdvt_back #(
		.GENES(GENES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_size     (lr_q),
		.discount      (disc_q),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.clearing      (clearing),
		.done          (done),
		.value         (value_raw),
		.written       (written)
	);

	assign value = $signed(value_raw);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// testbench of the td(0) value table: directed and random commands checked by a table predictor
module tb_top;
	import tdvt_pkg::*;

	localparam int TABLE_DEPTH = 1 << GENES_DEF;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 110;
	localparam int SETTLE      = 12;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    written;
	} td_result_t;

	// shadow table plus the queue of values the block still owes us
	class td_value_board;
		logic signed [VAL_W-1:0] values [TABLE_DEPTH];
		logic [REG_W-1:0]        lr;
		logic [REG_W-1:0]        disc;
		td_result_t              predicted_values [$];
		int errors, lookups, writes, skipped, saturated, settings;

		function new();
			lr   = LR_RESET;
			disc = DISC_RESET;
			foreach (values[i]) values[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
			if (idx == CFG_LR) lr = data;
			else if (idx == CFG_DISC) disc = data;
		endfunction

		function int waiting();
			return predicted_values.size();
		endfunction

		// td(0) step: both products floored toward minus infinity, only the sum saturates
		function void note_command(logic c, logic [GENES_DEF-1:0] si, logic [GENES_DEF-1:0] ni,
				logic signed [VAL_W-1:0] rw);
			longint pre, post, dp, d, inc, sum;
			td_result_t r;
			r.written = 1'b0;
			if (c == CMD_UPDATE && rw > 0) begin
				pre  = values[si];
				post = values[ni];
				dp   = (longint'(disc) * post) >>> 16;
				d    = longint'(rw) + dp - pre;
				inc  = (longint'(lr) * d) >>> 16;
				sum  = pre + inc;
				if (sum > longint'(VAL_MAX)) begin
					values[si] = VAL_MAX;
					saturated++;
				end else if (sum < longint'(VAL_MIN)) begin
					values[si] = VAL_MIN;
					saturated++;
				end else begin
					values[si] = VAL_W'(sum);
				end
				r.written = 1'b1;
				writes++;
			end else if (c == CMD_UPDATE) begin
				skipped++;
			end else begin
				lookups++;
			end
			r.value = values[si];
			predicted_values.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_result(logic signed [VAL_W-1:0] v, logic w);
			td_result_t r;
			if (predicted_values.size() == 0) begin
				report_mismatch($sformatf("result value=%0d written=%0b with none pending", v, w));
			end else begin
				r = predicted_values.pop_front();
				if (v !== r.value)
					report_mismatch($sformatf("value %0d, predicted %0d", v, r.value));
				if (w !== r.written)
					report_mismatch($sformatf("written %0b, predicted %0b", w, r.written));
			end
		endtask
	endclass

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    start       = 1'b0;
	logic                    cmd         = CMD_LOOKUP;
	logic [GENES_DEF-1:0]    state_index = '0;
	logic [GENES_DEF-1:0]    next_index  = '0;
	logic signed [VAL_W-1:0] reward      = '0;
	logic                    cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index   = CFG_LR;
	logic [REG_W-1:0]        cfg_data    = '0;
	logic                    busy;
	logic                    done;
	logic signed [VAL_W-1:0] value;
	logic                    written;

	td_value_board board = new();
	int unsigned cycles = 0;

	td_value_table_update u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.state_index(state_index),
		.next_index (next_index),
		.reward     (reward),
		.done       (done),
		.value      (value),
		.written    (written),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, board.waiting());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// monitor: every strobe is a result transfer, every start with busy low a command transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(value, written);
			if (start && !busy)
				board.note_command(cmd, state_index, next_index, reward);
		end
	end

	// present one command and hold it until the block takes it
	task send_command(input logic c, input logic [GENES_DEF-1:0] si,
			input logic [GENES_DEF-1:0] ni, input logic signed [VAL_W-1:0] rw);
		start       <= 1'b1;
		cmd         <= c;
		state_index <= si;
		next_index  <= ni;
		reward      <= rw;
		do @(posedge clk); while (busy);
	endtask

	task idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 19)) @(posedge clk);
	endtask

	// stop sending and let every owed result come back, plus the write pipeline tail
	task settle();
		start <= 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both registers, back to back, only while nothing is in flight
	task write_regs(input logic [REG_W-1:0] lr, input logic [REG_W-1:0] disc);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LR;
		cfg_data  <= lr;
		@(posedge clk);
		board.set_reg(CFG_LR, lr);
		cfg_index <= CFG_DISC;
		cfg_data  <= disc;
		@(posedge clk);
		board.set_reg(CFG_DISC, disc);
		cfg_we <= 1'b0;
		board.settings++;
	endtask

	// indexes lean on a few hot entries so updates keep feeding on each other
	function automatic logic [GENES_DEF-1:0] pick_index();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return GENES_DEF'($urandom_range(0, 7));
			4, 5:       return GENES_DEF'($urandom_range(TABLE_DEPTH - 8, TABLE_DEPTH - 1));
			default:    return GENES_DEF'($urandom_range(0, TABLE_DEPTH - 1));
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_reward();
		logic signed [VAL_W-1:0] rw;
		case ($urandom_range(0, 19))
			10, 11, 12: rw = $urandom;
			13, 14: begin
				rw = $urandom_range(1, 1 << 20);
				rw = -rw;
			end
			15:     rw = '0;
			16, 17: rw = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
			18:     rw = 32'sd1;
			19:     rw = VAL_MAX;
			default: rw = $urandom_range(1, 1 << 18);
		endcase
		return rw;
	endfunction

	function automatic logic [REG_W-1:0] pick_reg();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return REG_W'(65536);
			2:       return '1;
			3:       return REG_W'($urandom_range(0, 65536));
			4:       return REG_W'($urandom_range(0, 131071));
			default: return REG_W'($urandom_range(60000, 65536));
		endcase
	endfunction

	task send_random(input bit gaps);
		logic                 c;
		logic [GENES_DEF-1:0] si, ni;
		if (gaps && $urandom_range(0, 5) == 0)
			idle_burst();
		c  = ($urandom_range(0, 9) < 7) ? CMD_UPDATE : CMD_LOOKUP;
		si = pick_index();
		ni = ($urandom_range(0, 6) == 0) ? si : pick_index();
		send_command(c, si, ni, pick_reward());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass keeps busy high until every table entry is zeroed
		do @(posedge clk); while (busy);

		// reset settings: lookups of the cleared table, non-positive rewards, writing updates, shared index
		send_command(CMD_LOOKUP, '0, '1, VAL_MAX);
		send_command(CMD_LOOKUP, '1, '1, VAL_MIN);
		send_command(CMD_UPDATE, 10'd3, 10'd7, 32'sd0);
		send_command(CMD_UPDATE, 10'd3, 10'd7, -32'sd1);
		send_command(CMD_UPDATE, 10'd3, 10'd7, VAL_MIN);
		send_command(CMD_UPDATE, 10'd3, 10'd7, 32'sd1);
		idle_burst();
		send_command(CMD_UPDATE, 10'd7, 10'd3, VAL_MAX);
		send_command(CMD_UPDATE, 10'd7, 10'd7, 32'sh0001_0000);
		send_command(CMD_LOOKUP, 10'd7, 10'd0, 32'sd0);
		send_command(CMD_UPDATE, '0, '1, VAL_MAX);
		send_command(CMD_UPDATE, '1, '0, 32'sh0001_0000);
		settle();

		// factors near 2.0 push an entry to the top, then flip it to the bottom
		write_regs('1, '1);
		send_command(CMD_UPDATE, 10'd9, 10'd9, VAL_MAX);
		send_command(CMD_UPDATE, 10'd9, 10'd9, VAL_MAX);
		send_command(CMD_UPDATE, 10'd9, 10'd11, 32'sd1);
		send_command(CMD_UPDATE, 10'd9, 10'd9, 32'sd1);
		send_command(CMD_LOOKUP, 10'd9, 10'd9, 32'sd1);
		settle();

		// zero step size still counts as a write
		write_regs('0, '0);
		send_command(CMD_UPDATE, 10'd9, 10'd0, 32'sd5);
		send_command(CMD_UPDATE, 10'd12, 10'd9, 32'sd100);
		settle();

		// unit step: the entry takes the reward outright
		write_regs(REG_W'(65536), '0);
		send_command(CMD_UPDATE, 10'd12, 10'd9, VAL_MAX);
		settle();
		write_regs(REG_W'(1), REG_W'(1));
		send_command(CMD_UPDATE, 10'd12, 10'd12, 32'sd1);
		settle();

		// random phases, each under its own register setting; the last two run without gaps
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       write_regs(REG_W'(65536), REG_W'(65536));
				1:       write_regs('0, '1);
				2:       write_regs('1, '0);
				3:       write_regs(LR_RESET, DISC_RESET);
				default: write_regs(pick_reg(), pick_reg());
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off once mid-phase until the block has nothing left to return
				if (p == 4 && i == PHASE_ITEMS / 2)
					settle();
				send_random(p < PHASES - 2);
			end
			settle();
		end

		$display("covered %0d lookups, %0d writing and %0d skipped updates, %0d saturated",
			board.lookups, board.writes, board.skipped, board.saturated);
		$display("under %0d register settings, %0d mismatches", board.settings, board.errors);
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tdvt_pkg.sv
rtl/core/tdvt_front.sv
rtl/core/tdvt_queue.sv
rtl/core/tdvt_back.sv
rtl/core/td_value_table_update.sv
test/tb_top.sv
